[rtl/core/satw_pkg.sv]
// Shared constants and types for the sender ack window tracker.
// Used by sender_ack_window_tracker and the testbench; no dependencies.
package satw_pkg;

  localparam int SEQ_SPACE  = 2048;
  localparam int RING_DEPTH = 64;
  localparam int ACK_WINDOW = 32;

  localparam int SEQ_W    = $clog2(SEQ_SPACE);
  localparam int SLOT_W   = $clog2(RING_DEPTH);
  localparam int WIN_W    = $clog2(ACK_WINDOW);
  localparam int CNT_W    = 6;
  localparam int BITS_W   = 32;
  localparam int DROP_W   = 16;
  localparam int CMD_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_NEXT = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_SCAN = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_ACK_END,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

[rtl/core/satw_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module satw_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/sender_ack_window_tracker.sv]
// Sender ack window tracker: top level with sequence counter, slot ring and drop scan.
// Depends on satw_pkg and satw_ram.
//
// Each item is a command. A take-next command issues the next 11-bit sequence
// number and claims its ring slot. An ack report walks 32 sequence numbers
// back from ack_seq, one slot per cycle, reading the stored sequence from the
// registered slot RAM into a compare stage. A drop scan walks 32 slots from the
// slot after the current sequence, one per cycle. A no-operation command only
// returns a result. One item is worked on at a time; its result sits in an output
// register, so the next item is accepted while that result waits to be taken.
module sender_ack_window_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [satw_pkg::CMD_W-1:0]    in_cmd,
  input  logic [satw_pkg::SEQ_W-1:0]    in_ack_seq,
  input  logic [satw_pkg::BITS_W-1:0]   in_ack_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [satw_pkg::SEQ_W-1:0]    out_seq_number,
  output logic [satw_pkg::CNT_W-1:0]    out_newly_acked,
  output logic                          out_seq_mismatch,
  output logic [satw_pkg::CNT_W-1:0]    out_dropped_now,
  output logic [satw_pkg::DROP_W-1:0]   out_dropped_total
);

  satw_pkg::state_t state_r, state_nxt;

  logic [satw_pkg::SEQ_W-1:0]      next_seq_r, next_seq_nxt;
  logic [satw_pkg::DROP_W-1:0]     drop_count_r, drop_count_nxt;
  logic [satw_pkg::RING_DEPTH-1:0] slot_valid_r, slot_valid_nxt;
  logic [satw_pkg::RING_DEPTH-1:0] slot_acked_r, slot_acked_nxt;

  logic [satw_pkg::WIN_W-1:0]  step_r, step_nxt;
  logic [satw_pkg::SEQ_W-1:0]  idx_r, idx_nxt;
  logic [satw_pkg::BITS_W-1:0] bits_r, bits_nxt;
  logic [satw_pkg::SLOT_W-1:0] scan_slot_r, scan_slot_nxt;

  // Compare stage that lines up with the RAM read data.
  logic                       p_vld_r, p_vld_nxt;
  logic                       p_slot_valid_r, p_slot_valid_nxt;
  logic [satw_pkg::SEQ_W-1:0] p_idx_r, p_idx_nxt;

  logic [satw_pkg::CNT_W-1:0] newly_r, newly_nxt;
  logic                       mismatch_r, mismatch_nxt;
  logic [satw_pkg::CNT_W-1:0] dropped_r, dropped_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [satw_pkg::SEQ_W-1:0]  out_seq_r, out_seq_nxt;
  logic [satw_pkg::CNT_W-1:0]  out_newly_r, out_newly_nxt;
  logic                        out_mismatch_r, out_mismatch_nxt;
  logic [satw_pkg::CNT_W-1:0]  out_dropped_r, out_dropped_nxt;
  logic [satw_pkg::DROP_W-1:0] out_total_r, out_total_nxt;

  logic                        ram_wr_en;
  logic [satw_pkg::SLOT_W-1:0] ram_wr_addr;
  logic [satw_pkg::SEQ_W-1:0]  ram_wr_data;
  logic                        ram_rd_en;
  logic [satw_pkg::SLOT_W-1:0] ram_rd_addr;
  logic [satw_pkg::SEQ_W-1:0]  ram_rd_data;

  logic                        accept;
  logic [satw_pkg::SEQ_W-1:0]  seq_inc;
  logic [satw_pkg::SLOT_W-1:0] ack_slot;

  satw_ram #(
    .DEPTH (satw_pkg::RING_DEPTH),
    .WIDTH (satw_pkg::SEQ_W)
  ) u_seq_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_ready = (state_r == satw_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign seq_inc  = next_seq_r + satw_pkg::SEQ_W'(1);
  assign ack_slot = idx_r[satw_pkg::SLOT_W-1:0];

  assign out_valid         = out_valid_r;
  assign out_seq_number    = out_seq_r;
  assign out_newly_acked   = out_newly_r;
  assign out_seq_mismatch  = out_mismatch_r;
  assign out_dropped_now   = out_dropped_r;
  assign out_dropped_total = out_total_r;

  always_comb begin
    state_nxt        = state_r;
    next_seq_nxt     = next_seq_r;
    drop_count_nxt   = drop_count_r;
    slot_valid_nxt   = slot_valid_r;
    slot_acked_nxt   = slot_acked_r;
    step_nxt         = step_r;
    idx_nxt          = idx_r;
    bits_nxt         = bits_r;
    scan_slot_nxt    = scan_slot_r;
    p_vld_nxt        = 1'b0;
    p_slot_valid_nxt = p_slot_valid_r;
    p_idx_nxt        = p_idx_r;
    newly_nxt        = newly_r;
    mismatch_nxt     = mismatch_r;
    dropped_nxt      = dropped_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_seq_nxt      = out_seq_r;
    out_newly_nxt    = out_newly_r;
    out_mismatch_nxt = out_mismatch_r;
    out_dropped_nxt  = out_dropped_r;
    out_total_nxt    = out_total_r;
    ram_wr_en        = 1'b0;
    ram_wr_addr      = seq_inc[satw_pkg::SLOT_W-1:0];
    ram_wr_data      = seq_inc;
    ram_rd_en        = 1'b0;
    ram_rd_addr      = ack_slot;

    // A slot that is invalid, or that holds another sequence, flags a mismatch.
    if (p_vld_r && (!p_slot_valid_r || (ram_rd_data != p_idx_r))) begin
      mismatch_nxt = 1'b1;
    end

    case (state_r)
      satw_pkg::ST_IDLE: begin
        if (accept) begin
          newly_nxt     = '0;
          mismatch_nxt  = 1'b0;
          dropped_nxt   = '0;
          step_nxt      = '0;
          idx_nxt       = in_ack_seq;
          bits_nxt      = in_ack_bits;
          scan_slot_nxt = next_seq_r[satw_pkg::SLOT_W-1:0] + satw_pkg::SLOT_W'(1);
          case (satw_pkg::cmd_t'(in_cmd))
            satw_pkg::CMD_NEXT: begin
              next_seq_nxt = seq_inc;
              ram_wr_en    = 1'b1;
              slot_valid_nxt[seq_inc[satw_pkg::SLOT_W-1:0]] = 1'b1;
              slot_acked_nxt[seq_inc[satw_pkg::SLOT_W-1:0]] = 1'b0;
              state_nxt    = satw_pkg::ST_DONE;
            end
            satw_pkg::CMD_ACK:  state_nxt = satw_pkg::ST_ACK;
            satw_pkg::CMD_SCAN: state_nxt = satw_pkg::ST_SCAN;
            default:            state_nxt = satw_pkg::ST_DONE;
          endcase
        end
      end
      satw_pkg::ST_ACK: begin
        // Slots within one window are distinct, so acked bits update at issue.
        ram_rd_en        = 1'b1;
        p_vld_nxt        = bits_r[0];
        p_idx_nxt        = idx_r;
        p_slot_valid_nxt = slot_valid_r[ack_slot];
        if (bits_r[0] && !slot_acked_r[ack_slot]) begin
          slot_acked_nxt[ack_slot] = 1'b1;
          newly_nxt = newly_r + satw_pkg::CNT_W'(1);
        end
        idx_nxt  = idx_r - satw_pkg::SEQ_W'(1);
        bits_nxt = bits_r >> 1;
        step_nxt = step_r + satw_pkg::WIN_W'(1);
        if (step_r == satw_pkg::WIN_W'(satw_pkg::ACK_WINDOW - 1)) begin
          state_nxt = satw_pkg::ST_ACK_END;
        end
      end
      satw_pkg::ST_ACK_END: begin
        state_nxt = satw_pkg::ST_DONE;
      end
      satw_pkg::ST_SCAN: begin
        if (slot_valid_r[scan_slot_r] && !slot_acked_r[scan_slot_r]) begin
          slot_valid_nxt[scan_slot_r] = 1'b0;
          dropped_nxt = dropped_r + satw_pkg::CNT_W'(1);
          if (drop_count_r != {satw_pkg::DROP_W{1'b1}}) begin
            drop_count_nxt = drop_count_r + satw_pkg::DROP_W'(1);
          end
        end
        scan_slot_nxt = scan_slot_r + satw_pkg::SLOT_W'(1);
        step_nxt      = step_r + satw_pkg::WIN_W'(1);
        if (step_r == satw_pkg::WIN_W'(satw_pkg::ACK_WINDOW - 1)) begin
          state_nxt = satw_pkg::ST_DONE;
        end
      end
      satw_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_seq_nxt      = next_seq_r;
          out_newly_nxt    = newly_r;
          out_mismatch_nxt = mismatch_r;
          out_dropped_nxt  = dropped_r;
          out_total_nxt    = drop_count_r;
          state_nxt        = satw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = satw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= satw_pkg::ST_IDLE;
      next_seq_r   <= '0;
      drop_count_r <= '0;
      slot_valid_r <= '0;
      slot_acked_r <= '0;
      p_vld_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_seq_r   <= next_seq_nxt;
      drop_count_r <= drop_count_nxt;
      slot_valid_r <= slot_valid_nxt;
      slot_acked_r <= slot_acked_nxt;
      p_vld_r      <= p_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r         <= step_nxt;
    idx_r          <= idx_nxt;
    bits_r         <= bits_nxt;
    scan_slot_r    <= scan_slot_nxt;
    p_slot_valid_r <= p_slot_valid_nxt;
    p_idx_r        <= p_idx_nxt;
    newly_r        <= newly_nxt;
    mismatch_r     <= mismatch_nxt;
    dropped_r      <= dropped_nxt;
    out_seq_r      <= out_seq_nxt;
    out_newly_r    <= out_newly_nxt;
    out_mismatch_r <= out_mismatch_nxt;
    out_dropped_r  <= out_dropped_nxt;
    out_total_r    <= out_total_nxt;
  end

  // The compare stage only carries work issued during the ack walk.
  a_cmp_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> $past(state_r == satw_pkg::ST_ACK))
    else $error("compare stage loaded outside the ack walk");

  // Per-item counts never exceed the window.
  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == satw_pkg::ST_DONE) |->
      (newly_r <= satw_pkg::CNT_W'(satw_pkg::ACK_WINDOW)) &&
      (dropped_r <= satw_pkg::CNT_W'(satw_pkg::ACK_WINDOW)))
    else $error("per-item count beyond the window");

  // The running drop count never goes down.
  a_drop_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (drop_count_r >= $past(drop_count_r)))
    else $error("drop count decreased");

  // The sequence counter moves only when a take-next item is accepted.
  a_seq_only_on_next: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && (in_cmd == satw_pkg::CMD_NEXT)) |=> $stable(next_seq_r))
    else $error("sequence counter moved without a take-next item");

endmodule

[test/tb.sv]
// Self-checking testbench for sender_ack_window_tracker: directed and random commands,
// predicted by a ledger class that mirrors the slot ring; results checked in order.
// Depends on satw_pkg and the sender_ack_window_tracker RTL.
`timescale 1ns / 1ps

module tb;
  import satw_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int DRAIN_CYCLES = 48;
  localparam int RANDOM_ITEMS = 760;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    in_cmd;
  logic [SEQ_W-1:0]    in_ack_seq;
  logic [BITS_W-1:0]   in_ack_bits;
  logic                out_valid;
  logic                out_ready;
  logic [SEQ_W-1:0]    out_seq_number;
  logic [CNT_W-1:0]    out_newly_acked;
  logic                out_seq_mismatch;
  logic [CNT_W-1:0]    out_dropped_now;
  logic [DROP_W-1:0]   out_dropped_total;

  int in_max_gap;
  int out_max_gap;
  int cycle_count;

  sender_ack_window_tracker u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_ack_seq        (in_ack_seq),
    .in_ack_bits       (in_ack_bits),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_seq_number    (out_seq_number),
    .out_newly_acked   (out_newly_acked),
    .out_seq_mismatch  (out_seq_mismatch),
    .out_dropped_now   (out_dropped_now),
    .out_dropped_total (out_dropped_total)
  );

  class ack_ledger;
    typedef struct {
      logic [SEQ_W-1:0]  seq_number;
      logic [CNT_W-1:0]  newly_acked;
      logic              seq_mismatch;
      logic [CNT_W-1:0]  dropped_now;
      logic [DROP_W-1:0] dropped_total;
    } report_t;

    logic [SEQ_W-1:0]  next_seq;
    logic [SEQ_W-1:0]  slot_seq [RING_DEPTH];
    bit                slot_valid [RING_DEPTH];
    bit                slot_acked [RING_DEPTH];
    logic [DROP_W-1:0] drop_count;
    report_t           pending_reports [$];
    int                errors;

    function new();
      next_seq = '0;
      drop_count = '0;
      errors = 0;
      for (int k = 0; k < RING_DEPTH; k++) begin
        slot_seq[k] = '0;
        slot_valid[k] = 1'b0;
        slot_acked[k] = 1'b0;
      end
    endfunction

    function void take_command(cmd_t cmd, logic [SEQ_W-1:0] ack_seq,
                               logic [BITS_W-1:0] ack_bits);
      report_t rep;
      logic [SEQ_W-1:0] walk_seq;
      logic [SLOT_W-1:0] slot;
      rep.newly_acked = '0;
      rep.seq_mismatch = 1'b0;
      rep.dropped_now = '0;
      case (cmd)
        CMD_NEXT: begin
          next_seq = next_seq + 1'b1;
          slot = next_seq[SLOT_W-1:0];
          slot_seq[slot] = next_seq;
          slot_valid[slot] = 1'b1;
          slot_acked[slot] = 1'b0;
        end
        CMD_ACK: begin
          walk_seq = ack_seq;
          for (int k = 0; k < ACK_WINDOW; k++) begin
            if (ack_bits[k]) begin
              slot = walk_seq[SLOT_W-1:0];
              // A stale or invalid slot is flagged but still gets acked.
              if (!slot_valid[slot] || slot_seq[slot] != walk_seq)
                rep.seq_mismatch = 1'b1;
              if (!slot_acked[slot]) begin
                slot_acked[slot] = 1'b1;
                rep.newly_acked++;
              end
            end
            walk_seq = walk_seq - 1'b1;
          end
        end
        CMD_SCAN: begin
          slot = next_seq[SLOT_W-1:0] + 1'b1;
          for (int k = 0; k < ACK_WINDOW; k++) begin
            if (slot_valid[slot] && !slot_acked[slot]) begin
              slot_valid[slot] = 1'b0;
              rep.dropped_now++;
              if (drop_count != '1)
                drop_count++;
            end
            slot = slot + 1'b1;
          end
        end
        default: ;
      endcase
      rep.seq_number = next_seq;
      rep.dropped_total = drop_count;
      pending_reports.push_back(rep);
    endfunction

    // Four-state compare, so an unknown result bit counts as a mismatch.
    function void compare_field(string field, logic [31:0] expected, logic [31:0] actual);
      if (expected !== actual) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, expected, actual);
        errors++;
      end
    endfunction

    function void check_report(logic [SEQ_W-1:0] seq_number, logic [CNT_W-1:0] newly_acked,
                               logic seq_mismatch, logic [CNT_W-1:0] dropped_now,
                               logic [DROP_W-1:0] dropped_total);
      report_t exp;
      if (pending_reports.size() == 0) begin
        $display("%0t: result with no item outstanding, expected none, got seq %0d",
                 $time, seq_number);
        errors++;
        return;
      end
      exp = pending_reports.pop_front();
      compare_field("seq_number", 32'(exp.seq_number), 32'(seq_number));
      compare_field("newly_acked", 32'(exp.newly_acked), 32'(newly_acked));
      compare_field("seq_mismatch", 32'(exp.seq_mismatch), 32'(seq_mismatch));
      compare_field("dropped_now", 32'(exp.dropped_now), 32'(dropped_now));
      compare_field("dropped_total", 32'(exp.dropped_total), 32'(dropped_total));
    endfunction
  endclass

  ack_ledger ledger = new();

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Valid is lowered only when a gap follows, so back-to-back items keep it high.
  task automatic send_command(cmd_t cmd, logic [SEQ_W-1:0] ack_seq,
                              logic [BITS_W-1:0] ack_bits);
    int gap;
    gap = $urandom_range(0, in_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_ack_seq <= ack_seq;
    in_ack_bits <= ack_bits;
    do @(posedge clk); while (!in_ready);
    ledger.take_command(cmd, ack_seq, ack_bits);
  endtask

  // Mostly issues and acks close to the live sequence, with some stray acks, scans and no-operations.
  task automatic send_random_item();
    int roll;
    logic [SEQ_W-1:0] ack_seq;
    logic [SEQ_W-1:0] lag;
    logic [BITS_W-1:0] ack_bits;
    roll = $urandom_range(0, 99);
    ack_seq = SEQ_W'($urandom);
    ack_bits = $urandom;
    if (roll < 45) begin
      send_command(CMD_NEXT, ack_seq, ack_bits);
    end else if (roll < 70) begin
      lag = SEQ_W'($urandom_range(0, 4));
      ack_seq = ledger.next_seq - lag;
      case ($urandom_range(0, 2))
        0: ack_bits = $urandom & $urandom;
        1: ack_bits = 32'hFFFF_FFFF >> $urandom_range(0, 31);
        default: ;
      endcase
      send_command(CMD_ACK, ack_seq, ack_bits);
    end else if (roll < 80) begin
      send_command(CMD_ACK, ack_seq, ack_bits);
    end else if (roll < 92) begin
      send_command(CMD_SCAN, ack_seq, ack_bits);
    end else begin
      send_command(CMD_NOP, ack_seq, ack_bits);
    end
  endtask

  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_max_gap);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      ledger.check_report(out_seq_number, out_newly_acked, out_seq_mismatch,
                          out_dropped_now, out_dropped_total);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_NOP;
    in_ack_seq = '0;
    in_ack_bits = '0;
    out_ready = 1'b0;
    cycle_count = 0;
    in_max_gap = 5;
    out_max_gap = 5;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // An ack on the empty ring flags a mismatch, acks all 32 and wraps below zero.
    send_command(CMD_ACK, 11'd0, 32'hFFFF_FFFF);
    send_command(CMD_NOP, 11'h7FF, 32'hFFFF_FFFF);
    send_command(CMD_NOP, 11'd0, 32'h0);
    repeat (4) send_command(CMD_NEXT, 11'd0, 32'h0);
    send_command(CMD_ACK, 11'd4, 32'h0);
    send_command(CMD_ACK, 11'd3, 32'h3);
    send_command(CMD_ACK, 11'd3, 32'h3);
    // Slot 4 holds sequence 4, not 68: flagged, yet still counted as a new ack.
    send_command(CMD_ACK, 11'd68, 32'h1);
    send_command(CMD_ACK, 11'h7FF, 32'h8000_0000);
    send_command(CMD_SCAN, 11'h7FF, 32'hFFFF_FFFF);
    send_command(CMD_SCAN, 11'd0, 32'h0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_random_item();
    end

    repeat (30) send_random_item();
    in_valid <= 1'b0;

    while (ledger.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
